>>> rtl/core/quoted_bracket_depth_checker_top_macros.svh
`ifndef QUOTED_BRACKET_DEPTH_CHECKER_TOP_MACROS_SVH
`define QUOTED_BRACKET_DEPTH_CHECKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define QBDC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define QBDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/qbdc_pkg.sv
`default_nettype none

package qbdc_pkg;

   localparam int BYTE_W  = 8;
   localparam int DEPTH_W = 8;

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 8'd64;
   localparam logic [DEPTH_W-1:0] DEPTH_FULL  = 8'hFF;

   localparam logic [BYTE_W-1:0] CHAR_HASH      = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [BYTE_W-1:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [BYTE_W-1:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [BYTE_W-1:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [BYTE_W-1:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'h0A;

   typedef enum logic [2:0] {
      MODE_PLAIN      = 3'd0,
      MODE_SINGLE     = 3'd1,
      MODE_SINGLE_END = 3'd2,
      MODE_DOUBLE     = 3'd3,
      MODE_DOUBLE_ESC = 3'd4,
      MODE_COMMENT    = 3'd5
   } scan_mode_type;

   typedef struct packed {
      logic              fire;
      logic              is_last;
      logic [BYTE_W-1:0] text_byte;
   } scan_req_type;

endpackage

`default_nettype wire

>>> rtl/core/qbdc_scan.sv
`default_nettype none

module qbdc_scan (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire qbdc_pkg::scan_req_type         req,
   input  wire logic [qbdc_pkg::DEPTH_W-1:0]   max_depth,
   output logic                                too_deep
);
   import qbdc_pkg::*;

   scan_mode_type      mode_ff, mode_in, mode_step;
   logic [DEPTH_W-1:0] depth_ff, depth_in, depth_step;
   logic               error_ff, error_step;
   logic               error_in;
   logic               run_plain;
   logic [DEPTH_W:0]   depth_inc;
   logic [BYTE_W-1:0]  b;

   assign b         = req.text_byte;
   assign depth_inc = {1'b0, depth_ff} + {{DEPTH_W{1'b0}}, 1'b1};

   always_comb begin
      mode_step = mode_ff;
      run_plain = 1'b0;
      unique case (mode_ff)
         MODE_SINGLE: begin
            if (b == CHAR_SQUOTE) mode_step = MODE_SINGLE_END;
         end
         MODE_SINGLE_END: begin
            if (b == CHAR_SQUOTE) mode_step = MODE_SINGLE;
            else run_plain = 1'b1;
         end
         MODE_DOUBLE: begin
            if (b == CHAR_BACKSLASH) mode_step = MODE_DOUBLE_ESC;
            else if (b == CHAR_DQUOTE) mode_step = MODE_PLAIN;
         end
         MODE_DOUBLE_ESC: begin
            mode_step = MODE_DOUBLE;
         end
         MODE_COMMENT: begin
            if (b == CHAR_NEWLINE) mode_step = MODE_PLAIN;
         end
         default: begin
            run_plain = 1'b1;
         end
      endcase

      depth_step = depth_ff;
      error_step = error_ff;
      if (run_plain) begin
         mode_step = MODE_PLAIN;
         priority if (b == CHAR_HASH) begin
            mode_step = MODE_COMMENT;
         end else if (b == CHAR_SQUOTE) begin
            mode_step = MODE_SINGLE;
         end else if (b == CHAR_DQUOTE) begin
            mode_step = MODE_DOUBLE;
         end else if (b == CHAR_LBRACKET || b == CHAR_LBRACE) begin
            if (depth_inc > {1'b0, max_depth}) error_step = 1'b1;
            depth_step = depth_inc[DEPTH_W] ? DEPTH_FULL : depth_inc[DEPTH_W-1:0];
         end else if ((b == CHAR_RBRACKET || b == CHAR_RBRACE) && depth_ff != '0) begin
            depth_step = depth_ff - {{(DEPTH_W-1){1'b0}}, 1'b1};
         end else begin
            depth_step = depth_ff;
         end
      end
   end

   assign too_deep = error_step;

   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      error_in = error_ff;
      if (req.fire) begin
         if (req.is_last) begin
            mode_in  = MODE_PLAIN;
            depth_in = '0;
            error_in = 1'b0;
         end else begin
            mode_in  = mode_step;
            depth_in = depth_step;
            error_in = error_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         depth_ff <= '0;
         error_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
         error_ff <= error_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/quoted_bracket_depth_checker_top.sv
// channel | handshake          | payload
// req     | req_valid/req_stall | req_text_byte, req_is_last
// rsp     | rsp_valid/rsp_stall | rsp_too_deep
// csr     | csr_valid/csr_ready | csr_max_nesting_depth
//
// One request per cycle while req_stall is low; a request waits in the input register
// until it is scanned, a last request loading the result register once that is free.
// The result is valid once loaded there and holds while rsp_stall is high.
// req_stall rises only while a last request waits on a stalled result.
// Synchronous reset clears scan state, pipeline valids and sets the limit to 64.
`default_nettype none

module quoted_bracket_depth_checker_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [qbdc_pkg::BYTE_W-1:0]   req_text_byte,
   input  wire logic                          req_is_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_too_deep,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [qbdc_pkg::DEPTH_W-1:0]  csr_max_nesting_depth
);
   import qbdc_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic               in_last_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               req_take, scan_fire, rsp_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_deep_ff, rsp_deep_in;
   logic [DEPTH_W-1:0] max_ff, max_in;
   logic               scan_deep;
   scan_req_type       scan_req;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_fire = in_valid_ff && (!in_last_ff || rsp_free);
   assign req_stall = in_valid_ff && !scan_fire;
   assign req_take  = req_valid && !req_stall;

   assign scan_req.fire      = scan_fire;
   assign scan_req.is_last   = in_last_ff;
   assign scan_req.text_byte = in_byte_ff;

   qbdc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req       (scan_req),
      .max_depth (max_ff),
      .too_deep  (scan_deep)
   );

   assign in_valid_in  = req_take || (in_valid_ff && !scan_fire);
   assign rsp_valid_in = (scan_fire && in_last_ff) || (rsp_valid_ff && rsp_stall);
   assign rsp_deep_in  = (scan_fire && in_last_ff) ? scan_deep : rsp_deep_ff;
   assign max_in       = (csr_valid && csr_ready) ? csr_max_nesting_depth : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= DEPTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_is_last;
      end
      rsp_deep_ff <= rsp_deep_in;
   end

   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_too_deep = rsp_deep_ff;

endmodule

`default_nettype wire

>>> rtl/core/qbdc_checker.sv
`default_nettype none
`include "quoted_bracket_depth_checker_top_macros.svh"

module qbdc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_too_deep
);

   // input only backs up behind a waiting, stalled result
   `QBDC_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "req_stall without stalled rsp")

   // a stalled result holds
   `QBDC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_too_deep), "rsp changed while stalled")

   // nothing pending right after reset
   `QBDC_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid && !req_stall, "pipeline not empty after reset")

endmodule

bind quoted_bracket_depth_checker_top qbdc_checker u_qbdc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_too_deep (rsp_too_deep)
);

`default_nettype wire
